### rtl/core/bvp_pkg.sv
`timescale 1ns / 1ps

package bvp_pkg;

  // Default screen geometry of the framebuffer.
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 200;

  // Field widths of the channels.
  localparam int DATA_BYTE_W   = 8;
  localparam int FB_ADDRESS_W  = 16;
  localparam int PIXEL_INDEX_W = 8;

  // Configuration port and register widths.
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 9;
  localparam int IMAGE_WIDTH_W  = 9;
  localparam int IMAGE_HEIGHT_W = 8;
  localparam int COLOR_MODE_W   = 2;
  localparam int LIGHTNESS_W    = 7;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LIGHTNESS    = 4'd3;

  // Register reset values.
  localparam logic [IMAGE_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 9'd320;
  localparam logic [IMAGE_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 8'd200;
  localparam logic [COLOR_MODE_W-1:0]   RST_COLOR_MODE   = 2'd0;
  localparam logic [LIGHTNESS_W-1:0]    RST_LIGHTNESS    = 7'd4;

  // Color mode codes. With both bits set, grayscale wins.
  localparam logic [COLOR_MODE_W-1:0] MODE_PACK64    = 2'd0;
  localparam logic [COLOR_MODE_W-1:0] MODE_GRAY      = 2'd1;
  localparam logic [COLOR_MODE_W-1:0] MODE_LIGHTNESS = 2'd2;
  localparam logic [COLOR_MODE_W-1:0] MODE_GRAY_BOTH = 2'd3;

  // Byte phase codes within one pixel.
  localparam logic [1:0] PHASE_BLUE  = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_RED   = 2'd2;

  // Only the two top quotient bits of the lightness division are used.
  localparam int DIV_STEPS = 2;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Reciprocal of three for sums below 256: floor(s / 3) = (s * 171) >> 9.
  localparam logic [15:0] RECIP_THREE       = 16'd171;
  localparam int          RECIP_THREE_SHIFT = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pixel_start;
    logic use_divider;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/bvp_stream_if.sv
`timescale 1ns / 1ps

// Byte channel into the block.
interface bvp_byte_if;
  logic                           valid;
  logic                           ready;
  logic [bvp_pkg::DATA_BYTE_W-1:0] data_byte;
  logic                           frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// Pixel channel out of the block.
interface bvp_pixel_if;
  logic                             valid;
  logic                             ready;
  logic [bvp_pkg::FB_ADDRESS_W-1:0]  fb_address;
  logic [bvp_pkg::PIXEL_INDEX_W-1:0] pixel_index;
  logic                             frame_done;

  modport source (output valid, output fb_address, output pixel_index, output frame_done,
                  input ready);
  modport sink (input valid, input fb_address, input pixel_index, input frame_done,
                output ready);
endinterface

// Register write channel.
interface bvp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bvp_pkg::CFG_INDEX_W-1:0] reg_index;
  logic [bvp_pkg::CFG_DATA_W-1:0]  reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

### rtl/core/bmp24_to_vga8_pixel_stream.sv
`timescale 1ns / 1ps

// Converts the pixel bytes of a bottom-up 24-bit bitmap into framebuffer writes.
// pixel_in carries one data byte per transaction, blue, green, red; frame_start
// restarts the position counters before its byte. Row padding is dropped.
// pixel_out carries one transaction per pixel: centered framebuffer address,
// palette index and a frame_done flag on the last pixel of the image.
// cfg writes image_width, image_height, color_mode and lightness by index;
// it is always ready; the user must write it only while the block is idle, as
// the block itself does not enforce that. A byte that does not complete a pixel
// is taken in the idle state. The red byte is accepted and then emitted; in
// lightness mode, a restoring divider between the two finds the two brightness
// bits, one bit per cycle. No byte is taken until the pixel has been loaded
// into the output register.
// Reset restores the register defaults, clears the position counters and
// drops the output valid.
// When the receiver stalls, the result holds in the output register; the next
// pixel's bytes are still accepted and that pixel waits in its emit step.
module bmp24_to_vga8_pixel_stream #(
  parameter int SCREEN_WIDTH  = bvp_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = bvp_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  bvp_byte_if.sink           pixel_in,
  bvp_pixel_if.source        pixel_out,
  bvp_cfg_if.sink            cfg
);
  import bvp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  // Controller.
  bvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_in.valid),
    .in_ready (pixel_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  bvp_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (pixel_in.data_byte),
    .frame_start (pixel_in.frame_start),
    .cfg_write   (cfg.valid),
    .cfg_index   (cfg.reg_index),
    .cfg_data    (cfg.reg_data),
    .out_valid   (pixel_out.valid),
    .out_ready   (pixel_out.ready),
    .fb_address  (pixel_out.fb_address),
    .pixel_index (pixel_out.pixel_index),
    .frame_done  (pixel_out.frame_done)
  );

endmodule

### rtl/core/bvp_ctrl.sv
`timescale 1ns / 1ps

module bvp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvp_pkg::dp_status_t status,
  output bvp_pkg::ctrl_cmd_t  cmd
);
  import bvp_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
        if (in_valid && status.pixel_start) begin
          state_next = status.use_divider ? ST_DIVIDE : ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A pixel never waits in the emit state once the output slot is free.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && status.out_free) |=> state == ST_IDLE)
    else $error("emit state did not return to idle");

  // A pixel in lightness mode goes through the divider.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.take_byte && status.pixel_start && status.use_divider) |=> state == ST_DIVIDE)
    else $error("lightness pixel skipped the divider");

  // No byte is taken while a pixel is still being worked on.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE || state == ST_EMIT) |-> !cmd.take_byte)
    else $error("byte taken while busy");

endmodule

### rtl/core/bvp_datapath.sv
`timescale 1ns / 1ps

module bvp_datapath #(
  parameter int SCREEN_WIDTH  = bvp_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = bvp_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bvp_pkg::ctrl_cmd_t                  cmd,
  output bvp_pkg::dp_status_t                 status,
  input  logic [bvp_pkg::DATA_BYTE_W-1:0]     data_byte,
  input  logic                                frame_start,
  input  logic                                cfg_write,
  input  logic [bvp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bvp_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bvp_pkg::FB_ADDRESS_W-1:0]    fb_address,
  output logic [bvp_pkg::PIXEL_INDEX_W-1:0]   pixel_index,
  output logic                                frame_done
);
  import bvp_pkg::*;

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);

  // Configuration registers.
  logic [IMAGE_WIDTH_W-1:0]  image_width;
  logic [IMAGE_HEIGHT_W-1:0] image_height;
  logic [COLOR_MODE_W-1:0]   color_mode;
  logic [LIGHTNESS_W-1:0]    lightness;

  // Position state.
  logic [1:0] byte_phase;
  logic [1:0] byte_phase_next;
  logic [7:0] held_blue;
  logic [7:0] held_green;
  logic [8:0] column_count;
  logic [8:0] column_count_next;
  logic [7:0] row_count;
  logic [7:0] row_count_next;
  logic [1:0] pad_count;
  logic [1:0] pad_count_next;
  logic       frame_finished;
  logic       frame_finished_next;

  // Pixel registers latched on the red byte.
  logic [XW-1:0] pix_x;
  logic [YW-1:0] pix_y;
  logic [5:0]    pix_packed;
  logic [7:0]    pix_gray_sum;
  logic          pix_last;
  logic [7:0]    div_den;
  logic [7:0]    div_rem;
  logic [7:0]    div_low;
  logic [1:0]    div_q;
  logic [DIV_CNT_W-1:0] div_count;

  // Effective state after an optional frame restart.
  logic [1:0] phase_e;
  logic [8:0] col_e;
  logic [7:0] row_e;
  logic [1:0] pad_e;
  logic       fin_e;
  logic       pixel_start;

  // Clamped image size and the pixel position.
  logic [8:0] eff_w;
  logic [7:0] eff_h;
  logic [8:0] col_clamp;
  logic [7:0] row_clamp;
  logic       last_col;
  logic       last_row;
  logic [9:0] col_sum;
  logic [8:0] row_sum;
  logic [9:0] rgb_sum;

  // Divider step.
  logic [8:0] div_trial;
  logic       div_ge;

  // Output index and address.
  logic [15:0] gray_prod;
  logic [7:0]  index_val;
  logic [FB_ADDRESS_W-1:0] address_val;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      color_mode   <= RST_COLOR_MODE;
      lightness    <= RST_LIGHTNESS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMAGE_HEIGHT_W-1:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[COLOR_MODE_W-1:0];
        REG_LIGHTNESS:    lightness    <= cfg_data[LIGHTNESS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Image size, zero taken as one and saturated to the screen.
  always_comb begin
    if (image_width == '0) begin
      eff_w = 9'd1;
    end else if ({23'b0, image_width} > 32'(SCREEN_WIDTH)) begin
      eff_w = 9'(SCREEN_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = 8'd1;
    end else if ({24'b0, image_height} > 32'(SCREEN_HEIGHT)) begin
      eff_h = 8'(SCREEN_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  // Effective state and next position state for a taken byte.
  always_comb begin
    phase_e = frame_start ? PHASE_BLUE : byte_phase;
    col_e   = frame_start ? 9'd0 : column_count;
    row_e   = frame_start ? 8'd0 : row_count;
    pad_e   = frame_start ? 2'd0 : pad_count;
    fin_e   = frame_start ? 1'b0 : frame_finished;

    pixel_start = !fin_e && (pad_e == 2'd0) && (phase_e == PHASE_RED);

    col_sum  = {1'b0, col_e} + 10'd1;
    row_sum  = {1'b0, row_e} + 9'd1;
    last_col = col_sum >= {1'b0, eff_w};
    last_row = row_sum >= {1'b0, eff_h};
    col_clamp = (col_e < eff_w) ? col_e : 9'(eff_w - 9'd1);
    row_clamp = (row_e < eff_h) ? row_e : 8'(eff_h - 8'd1);

    byte_phase_next     = phase_e;
    column_count_next   = col_e;
    row_count_next      = row_e;
    pad_count_next      = pad_e;
    frame_finished_next = fin_e;
    if (!fin_e) begin
      if (pad_e != 2'd0) begin
        pad_count_next = 2'(pad_e - 2'd1);
      end else if (phase_e == PHASE_GREEN) begin
        byte_phase_next = PHASE_RED;
      end else if (phase_e != PHASE_RED) begin
        byte_phase_next = PHASE_GREEN;
      end else begin
        byte_phase_next = PHASE_BLUE;
        if (last_col) begin
          column_count_next = 9'd0;
          if (last_row) begin
            frame_finished_next = 1'b1;
          end else begin
            row_count_next = row_sum[7:0];
            pad_count_next = eff_w[1:0];
          end
        end else begin
          column_count_next = col_sum[8:0];
        end
      end
    end
  end

  // Position state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= PHASE_BLUE;
      column_count   <= '0;
      row_count      <= '0;
      pad_count      <= '0;
      frame_finished <= 1'b0;
    end else if (cmd.take_byte) begin
      byte_phase     <= byte_phase_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      pad_count      <= pad_count_next;
      frame_finished <= frame_finished_next;
    end
  end

  // Held color bytes.
  always_ff @(posedge clk) begin
    if (cmd.take_byte && !fin_e && pad_e == 2'd0) begin
      if (phase_e == PHASE_GREEN) begin
        held_green <= data_byte;
      end else if (phase_e != PHASE_RED) begin
        held_blue <= data_byte;
      end
    end
  end

  assign rgb_sum = {2'b0, data_byte} + {2'b0, held_green} + {2'b0, held_blue};

  // Latch the pixel: screen position, packed color, gray sum and last-pixel flag.
  always_ff @(posedge clk) begin
    if (cmd.take_byte && pixel_start) begin
      pix_x <= XW'(((32'(SCREEN_WIDTH) - {23'b0, eff_w}) >> 1) + {23'b0, col_clamp});
      pix_y <= YW'(((32'(SCREEN_HEIGHT) - {24'b0, eff_h}) >> 1)
                   + {24'b0, eff_h} - 32'd1 - {24'b0, row_clamp});
      pix_packed   <= {held_blue[7:6], held_green[7:6], data_byte[7:6]};
      pix_gray_sum <= {2'b0, data_byte[7:2]} + {2'b0, held_green[7:2]}
                      + {2'b0, held_blue[7:2]};
      pix_last     <= last_col && last_row;
    end
  end

  // Restoring divider for the top two bits of the brightness average.
  assign div_trial = {div_rem, div_low[7]};
  assign div_ge    = div_trial >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (cmd.take_byte && pixel_start) begin
      div_den   <= 8'd3 + {1'b0, lightness};
      div_rem   <= 8'(({9'b0, lightness} + 16'(rgb_sum[9:8])));
      div_low   <= rgb_sum[7:0];
      div_count <= '0;
    end else if (cmd.div_step) begin
      div_rem   <= div_ge ? 8'(div_trial - {1'b0, div_den}) : div_trial[7:0];
      div_low   <= {div_low[6:0], 1'b0};
      div_q     <= {div_q[0], div_ge};
      div_count <= DIV_CNT_W'(div_count + 1'b1);
    end
  end

  // Palette index and framebuffer address.
  always_comb begin
    gray_prod = {8'b0, pix_gray_sum} * RECIP_THREE;
    case (color_mode) inside
      MODE_GRAY, MODE_GRAY_BOTH: index_val = 8'(gray_prod >> RECIP_THREE_SHIFT);
      MODE_LIGHTNESS:            index_val = {div_q, pix_packed};
      default:                   index_val = {2'b0, pix_packed};
    endcase
    address_val = FB_ADDRESS_W'(32'(pix_y) * 32'(SCREEN_WIDTH) + 32'(pix_x));
  end

  // Output register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      fb_address  <= address_val;
      pixel_index <= index_val;
      frame_done  <= pix_last;
    end
  end

  // Status to the controller.
  always_comb begin
    status.pixel_start = pixel_start;
    status.use_divider = (color_mode == MODE_LIGHTNESS);
    status.div_done    = (div_count == DIV_CNT_W'(DIV_STEPS - 1));
    status.out_free    = !out_valid || out_ready;
  end

  // A finished frame takes no more pixels until a restart.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.take_byte && !frame_start && frame_finished) |-> !pixel_start)
    else $error("pixel started after the frame was finished");

  // Padding is skipped before any color byte of the next row.
  assert property (@(posedge clk) disable iff (rst)
    (pad_count != 2'd0) |-> (byte_phase == PHASE_BLUE))
    else $error("padding pending in the middle of a pixel");

  // A stalled result stays in place.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fb_address) && $stable(pixel_index)))
    else $error("stalled result changed");

endmodule

### tb/tb_bmp24_to_vga8_pixel_stream.sv
`timescale 1ns / 1ps

module tb_bmp24_to_vga8_pixel_stream;
  import bvp_pkg::*;

  localparam int SCREEN_W       = DEF_SCREEN_WIDTH;
  localparam int SCREEN_H       = DEF_SCREEN_HEIGHT;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;
  localparam int TRUNC_BYTES    = 240;

  // Register index that decodes to nothing; a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'd15;

  typedef struct packed {
    logic [FB_ADDRESS_W-1:0]  fb_address;
    logic [PIXEL_INDEX_W-1:0] pixel_index;
    logic                     frame_done;
  } pixel_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bvp_byte_if  in_ch ();
  bvp_pixel_if out_ch ();
  bvp_cfg_if   cfg_ch ();

  bmp24_to_vga8_pixel_stream u_top (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (in_ch),
    .pixel_out (out_ch),
    .cfg       (cfg_ch)
  );

  // Shadow copy of the registers.
  logic [IMAGE_WIDTH_W-1:0]  img_width;
  logic [IMAGE_HEIGHT_W-1:0] img_height;
  logic [COLOR_MODE_W-1:0]   color_mode;
  logic [LIGHTNESS_W-1:0]    light_weight;

  // Shadow copy of the position state.
  logic [1:0] phase;
  logic [7:0] held_b;
  logic [7:0] held_g;
  int         col_pos;
  int         row_pos;
  int         pad_left;
  bit         frame_over;

  pixel_write_t pending_writes[$];

  int bytes_sent     = 0;
  int pixels_checked = 0;
  int frames_started = 0;
  int reg_writes     = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  bit gaps_on        = 1'b1;
  bit stalls_on      = 1'b1;

  always #4 clk = ~clk;

  function automatic int clamp_dim(int v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Palette index of one pixel under the current color mode.
  function automatic logic [7:0] palette_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [7:0] pack_bits;
    int         lum;
    pack_bits = {2'b00, b[7:6], g[7:6], r[7:6]};
    if (color_mode == MODE_GRAY || color_mode == MODE_GRAY_BOTH) begin
      return 8'((int'(r >> 2) + int'(g >> 2) + int'(b >> 2)) / 3);
    end
    if (color_mode == MODE_LIGHTNESS) begin
      lum = (int'(r) + int'(g) + int'(b) + 256 * int'(light_weight)) / (3 + int'(light_weight));
      return (8'(lum) & 8'hC0) | pack_bits;
    end
    return pack_bits;
  endfunction

  // Advances the shadow state by one accepted byte and queues the pixel write it completes.
  function automatic void predict_byte(logic [7:0] value, logic restart);
    int           w, h, col, row, x, y;
    bit           last_col, last_row;
    pixel_write_t wr;
    w = clamp_dim(int'(img_width), SCREEN_W);
    h = clamp_dim(int'(img_height), SCREEN_H);
    if (restart) begin
      phase      = PHASE_BLUE;
      col_pos    = 0;
      row_pos    = 0;
      pad_left   = 0;
      frame_over = 1'b0;
    end
    if (frame_over) return;
    if (pad_left != 0) begin
      pad_left--;
      return;
    end
    if (phase == PHASE_GREEN) begin
      held_g = value;
      phase  = PHASE_RED;
      return;
    end
    if (phase != PHASE_RED) begin
      held_b = value;
      phase  = PHASE_GREEN;
      return;
    end

    // Red byte: the pixel is complete.
    phase          = PHASE_BLUE;
    wr.pixel_index = palette_of(value, held_g, held_b);
    col            = (col_pos < w) ? col_pos : w - 1;
    row            = (row_pos < h) ? row_pos : h - 1;
    x              = (SCREEN_W - w) / 2 + col;
    y              = (SCREEN_H - h) / 2 + (h - 1 - row);
    wr.fb_address  = 16'(y * SCREEN_W + x);
    last_col       = (col_pos + 1) >= w;
    last_row       = (row_pos + 1) >= h;
    wr.frame_done  = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      if (last_row) begin
        frame_over = 1'b1;
      end else begin
        row_pos  = (row_pos + 1) & 8'hFF;
        pad_left = w & 3;
      end
    end else begin
      col_pos = (col_pos + 1) & 9'h1FF;
    end
    pending_writes.push_back(wr);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one byte transaction; starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] value, input logic restart);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= value;
    in_ch.frame_start <= restart;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(value, restart);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic restart);
    send_byte(b, restart);
    send_byte(g, 1'b0);
    send_byte(r, 1'b0);
  endtask

  // Holds the sender until every pixel write has come out and the block is quiet.
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_IMAGE_WIDTH:  img_width    = value[IMAGE_WIDTH_W-1:0];
      REG_IMAGE_HEIGHT: img_height   = value[IMAGE_HEIGHT_W-1:0];
      REG_COLOR_MODE:   color_mode   = value[COLOR_MODE_W-1:0];
      REG_LIGHTNESS:    light_weight = value[LIGHTNESS_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Each color mode on the reset geometry, including lightness values 120 and 0.
  task automatic test_color_modes();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    drain_and_settle();
    write_reg(REG_COLOR_MODE, 9'(MODE_GRAY));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    drain_and_settle();
    write_reg(REG_COLOR_MODE, 9'(MODE_LIGHTNESS));
    write_reg(REG_LIGHTNESS, 9'd120);
    send_pixel(8'h40, 8'h80, 8'hC0, 1'b0);
    drain_and_settle();
    write_reg(REG_LIGHTNESS, 9'd0);
    send_pixel(8'hC0, 8'h7F, 8'h01, 1'b0);
    drain_and_settle();
    write_reg(REG_COLOR_MODE, 9'(MODE_GRAY_BOTH));
    send_pixel(8'h3F, 8'hA5, 8'hFE, 1'b0);
  endtask

  // Zero and oversize dimensions, bytes after the frame, and row padding.
  task automatic test_geometry_edges();
    drain_and_settle();
    write_reg(REG_COLOR_MODE, 9'(MODE_PACK64));
    write_reg(REG_IMAGE_WIDTH, 9'd0);
    write_reg(REG_IMAGE_HEIGHT, 9'd0);
    send_pixel(8'hC0, 8'h80, 8'h40, 1'b1);
    send_byte(8'hFF, 1'b0);
    drain_and_settle();
    write_reg(REG_IMAGE_WIDTH, 9'h1FF);
    write_reg(REG_IMAGE_HEIGHT, 9'h1FF);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    drain_and_settle();
    write_reg(REG_IMAGE_WIDTH, 9'd1);
    write_reg(REG_IMAGE_HEIGHT, 9'd2);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
  endtask

  // Random frames: mostly whole frames, some cut short, some resized mid-frame, some noise.
  task automatic test_random_frames(input int byte_budget, input bit with_idling);
    int stop_at, w_reg, h_reg, w, h, frame_len, cap, change_at;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      drain_and_settle();
      gaps_on   = with_idling && ($urandom_range(0, 3) != 0);
      stalls_on = with_idling && ($urandom_range(0, 3) != 0);

      case ($urandom_range(0, 19))
        0: w_reg = 0;
        1: w_reg = SCREEN_W;
        2: w_reg = 511;
        3: w_reg = $urandom_range(13, SCREEN_W - 1);
        default: w_reg = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 19))
        0: h_reg = 0;
        1: h_reg = SCREEN_H;
        2: h_reg = 255;
        3: h_reg = $urandom_range(7, SCREEN_H - 1);
        default: h_reg = $urandom_range(1, 6);
      endcase
      write_reg(REG_IMAGE_WIDTH, 9'(w_reg));
      write_reg(REG_IMAGE_HEIGHT, 9'(h_reg));
      write_reg(REG_COLOR_MODE, 9'($urandom_range(0, 3)));
      case ($urandom_range(0, 5))
        0: write_reg(REG_LIGHTNESS, 9'd0);
        1: write_reg(REG_LIGHTNESS, 9'd120);
        2: write_reg(REG_LIGHTNESS, 9'd127);
        default: write_reg(REG_LIGHTNESS, 9'($urandom_range(0, 511)));
      endcase
      if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE, 9'($urandom_range(0, 511)));

      w         = clamp_dim(w_reg, SCREEN_W);
      h         = clamp_dim(h_reg, SCREEN_H);
      frame_len = 3 * w * h + (w & 3) * (h - 1);

      if ($urandom_range(0, 9) == 0) begin
        // Noise with the odd restart.
        repeat ($urandom_range(1, 24)) send_byte(rand_byte(), $urandom_range(0, 7) == 0);
      end else begin
        cap = frame_len;
        if ($urandom_range(0, 8) == 0 || cap > TRUNC_BYTES) begin
          cap = $urandom_range(1, (cap < TRUNC_BYTES) ? cap : TRUNC_BYTES);
        end
        change_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, cap) : -1;
        for (int k = 0; k < cap; k++) begin
          // Resize in the middle of the frame so positions can run past the new size.
          if (k == change_at) begin
            drain_and_settle();
            write_reg(REG_IMAGE_WIDTH, 9'($urandom_range(0, 16)));
            write_reg(REG_IMAGE_HEIGHT, 9'($urandom_range(0, 8)));
          end
          send_byte(rand_byte(), k == 0);
        end
        frames_started++;
        repeat ($urandom_range(0, 3)) send_byte(rand_byte(), 1'b0);
      end
    end
  endtask

  // Receiver side: random stall bursts.
  initial begin
    int hold;
    hold         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each pixel write transaction against the oldest prediction.
  always @(posedge clk) begin
    pixel_write_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.fb_address  = out_ch.fb_address;
      got.pixel_index = out_ch.pixel_index;
      got.frame_done  = out_ch.frame_done;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: unexpected pixel write addr=%0d index=0x%02h done=%0b",
                   got.fb_address, got.pixel_index, got.frame_done);
        end
      end else begin
        want = pending_writes.pop_front();
        pixels_checked++;
        if (got.fb_address !== want.fb_address || got.pixel_index !== want.pixel_index ||
            got.frame_done !== want.frame_done) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: pixel %0d expected addr=%0d index=0x%02h done=%0b", pixels_checked,
                     want.fb_address, want.pixel_index, want.frame_done);
            $display("ERROR: pixel %0d actual   addr=%0d index=0x%02h done=%0b", pixels_checked,
                     got.fb_address, got.pixel_index, got.frame_done);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d pixel writes outstanding",
               idle_cycles, pending_writes.size());
      $display("** bmp24_to_vga8_pixel_stream: FAILED **");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.frame_start = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = '0;
    cfg_ch.reg_data   = '0;
    img_width         = RST_IMAGE_WIDTH;
    img_height        = RST_IMAGE_HEIGHT;
    color_mode        = RST_COLOR_MODE;
    light_weight      = RST_LIGHTNESS;
    phase             = PHASE_BLUE;
    held_b            = '0;
    held_g            = '0;
    col_pos           = 0;
    row_pos           = 0;
    pad_left          = 0;
    frame_over        = 1'b0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_color_modes();
    test_geometry_edges();
    test_random_frames(1650, 1'b1);
    // Closing stretch at full rate on both sides.
    test_random_frames(250, 1'b0);
    drain_and_settle();

    $display("Sent %0d bytes over %0d random frames with %0d register writes; %0d pixels checked.",
             bytes_sent, frames_started, reg_writes, pixels_checked);
    $display("Covered all color modes, clamped sizes, padding, trailing bytes and resizes.");
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("** bmp24_to_vga8_pixel_stream: PASSED **");
    end else begin
      $display("** bmp24_to_vga8_pixel_stream: FAILED **");
    end
    $finish;
  end

endmodule

### bmp24_to_vga8_pixel_stream.f
rtl/core/bvp_pkg.sv
rtl/core/bvp_stream_if.sv
rtl/core/bvp_ctrl.sv
rtl/core/bvp_datapath.sv
rtl/core/bmp24_to_vga8_pixel_stream.sv
tb/tb_bmp24_to_vga8_pixel_stream.sv
